// ===== rtl/spc_pkg.sv =====
// Shared constants and types for the skin pixel classifier.
`default_nettype none

package spc_pkg;

	// Inverse covariance of the hue/saturation skin model, unsigned Q.24.
	localparam logic        [16:0] INV_A  = 17'd101502;
	localparam logic signed [15:0] INV_B2 = 16'sd14226;  // twice the cross term
	localparam logic        [12:0] INV_C  = 13'd6422;

	// Configuration register indexes (byte address is four times the index).
	localparam logic [2:0] REG_THRESHOLD_LAMBDA = 3'd0;
	localparam logic [2:0] REG_THRESHOLD_VALUE  = 3'd1;
	localparam logic [2:0] REG_CR_LOW           = 3'd2;
	localparam logic [2:0] REG_CR_HIGH          = 3'd3;
	localparam logic [2:0] REG_CB_LOW           = 3'd4;
	localparam logic [2:0] REG_CB_HIGH          = 3'd5;
	localparam logic [2:0] REG_MEAN_HUE_Q4      = 3'd6;
	localparam logic [2:0] REG_MEAN_SAT_Q4      = 3'd7;

	// Widths of the distance pipeline.
	localparam int DIFF_W  = 13;  // signed Q.4 offsets from the mean
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SQ_W    = 24;  // magnitude of a squared offset
	localparam int TERM_A_W = SQ_W + 17;
	localparam int TERM_B_W = PROD_W + 16;
	localparam int TERM_C_W = SQ_W + 13;
	localparam int LAMBDA_W = 43;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} spc_adv_t;

endpackage

`default_nettype wire

// ===== rtl/skin_pixel_classifier.sv =====
// Top level of the skin pixel classifier: stream ports, registers and pipeline control.
//
// Usage: one pixel per transaction arrives on the slave stream (s_tvalid,
// s_tready, s_tdata) and one classification per pixel leaves on the master
// stream (m_tvalid, m_tready, m_tdata). A pixel is skin when either the
// Mahalanobis hue/saturation test or the Cr/Cb box test passes.
// Throughput is one pixel per cycle while the receiver does not stall; the figure is set
// by the four-stage pipeline (offsets, squares and cross product, constant weighting,
// sum and compare), in which every stage not held by a stall takes a new pixel each clock.
// The result on m_tdata is held in the fourth stage, and the first stage loads at
// the accepting edge itself.
// When the receiver stalls, each occupied stage still moves into an empty stage ahead
// of it and holds only behind a full one, so bubbles close up and nothing is lost or
// repeated; s_tready falls only once the whole pipeline is full.
// Reset (arst_n low) empties the pipeline and loads the registers with their
// default model and thresholds. The APB port writes a register at the access
// cycle; registers should be changed only while no pixel is in flight.
`default_nettype none

module skin_pixel_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Pixel stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // hue[7:0], sat[15:8], val[23:16], cr[31:24], cb[39:32]
	// Classification stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // skin[0], cov_hit[1], box_hit[2], zeros above
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import spc_pkg::*;

	// Configuration registers.
	logic [5:0]  threshold_lambda_q;
	logic [7:0]  threshold_value_q;
	logic [7:0]  cr_low_q, cr_high_q, cb_low_q, cb_high_q;
	logic [11:0] mean_hue_q4_q, mean_sat_q4_q;

	logic [2:0] reg_index;
	logic       cfg_write;

	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_lambda_q <= 6'd2;
			threshold_value_q  <= 8'd40;
			cr_low_q           <= 8'd128;
			cr_high_q          <= 8'd164;
			cb_low_q           <= 8'd91;
			cb_high_q          <= 8'd127;
			mean_hue_q4_q      <= 12'd1838;
			mean_sat_q4_q      <= 12'd905;
		end else if (cfg_write) begin
			case (reg_index)
				REG_THRESHOLD_LAMBDA: threshold_lambda_q <= pwdata[5:0];
				REG_THRESHOLD_VALUE:  threshold_value_q  <= pwdata[7:0];
				REG_CR_LOW:           cr_low_q           <= pwdata[7:0];
				REG_CR_HIGH:          cr_high_q          <= pwdata[7:0];
				REG_CB_LOW:           cb_low_q           <= pwdata[7:0];
				REG_CB_HIGH:          cb_high_q          <= pwdata[7:0];
				REG_MEAN_HUE_Q4:      mean_hue_q4_q      <= pwdata[11:0];
				REG_MEAN_SAT_Q4:      mean_sat_q4_q      <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_THRESHOLD_LAMBDA: prdata = {26'd0, threshold_lambda_q};
			REG_THRESHOLD_VALUE:  prdata = {24'd0, threshold_value_q};
			REG_CR_LOW:           prdata = {24'd0, cr_low_q};
			REG_CR_HIGH:          prdata = {24'd0, cr_high_q};
			REG_CB_LOW:           prdata = {24'd0, cb_low_q};
			REG_CB_HIGH:          prdata = {24'd0, cb_high_q};
			REG_MEAN_HUE_Q4:      prdata = {20'd0, mean_hue_q4_q};
			REG_MEAN_SAT_Q4:      prdata = {20'd0, mean_sat_q4_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Input fields.
	logic [7:0] in_hue, in_sat, in_val, in_cr, in_cb;
	assign in_hue = s_tdata[7:0];
	assign in_sat = s_tdata[15:8];
	assign in_val = s_tdata[23:16];
	assign in_cr  = s_tdata[31:24];
	assign in_cb  = s_tdata[39:32];

	// Pipeline control: a stage loads when it is empty or the stage ahead loads,
	// so a stall at the output only freezes the stages that are occupied.
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     en_s4;
	spc_adv_t adv;

	assign en_s4    = !v_s4 || m_tready;
	assign adv.s3   = !v_s3 || en_s4;
	assign adv.s2   = !v_s2 || adv.s3;
	assign adv.s1   = !v_s1 || adv.s2;
	assign s_tready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= s_tvalid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (en_s4)  v_s4 <= v_s3;
		end
	end

	// The brightness and box tests are cheap; they are settled in the first
	// stage and travel alongside the distance terms.
	logic bright_s1, bright_s2, bright_s3;
	logic box_s1, box_s2, box_s3;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			bright_s1 <= in_val >= threshold_value_q;
			box_s1    <= (in_cr > cr_low_q) && (in_cr < cr_high_q) &&
			             (in_cb > cb_low_q) && (in_cb < cb_high_q);
		end
		if (adv.s2) begin
			bright_s2 <= bright_s1;
			box_s2    <= box_s1;
		end
		if (adv.s3) begin
			bright_s3 <= bright_s2;
			box_s3    <= box_s2;
		end
	end

	logic        [TERM_A_W-1:0] term_a_s3;
	logic signed [TERM_B_W-1:0] term_b_s3;
	logic        [TERM_C_W-1:0] term_c_s3;

	spc_distance u_distance (
		.clk         (clk),
		.adv         (adv),
		.hue         (in_hue),
		.sat         (in_sat),
		.mean_hue_q4 (mean_hue_q4_q),
		.mean_sat_q4 (mean_sat_q4_q),
		.term_a_s3   (term_a_s3),
		.term_b_s3   (term_b_s3),
		.term_c_s3   (term_c_s3)
	);

	// Lambda is Q.32 and never negative, so comparing its integer part with the
	// limit is the same as comparing it with the limit shifted up by 32.
	logic signed [LAMBDA_W-1:0] lambda;
	logic                       cov_c;

	assign lambda = $signed({{(LAMBDA_W-TERM_A_W){1'b0}}, term_a_s3}) +
	                {{(LAMBDA_W-TERM_B_W){term_b_s3[TERM_B_W-1]}}, term_b_s3} +
	                $signed({{(LAMBDA_W-TERM_C_W){1'b0}}, term_c_s3});
	assign cov_c  = bright_s3 &&
	                (lambda[LAMBDA_W-1:32] < {{(LAMBDA_W-38){1'b0}}, threshold_lambda_q});

	logic skin_s4, cov_s4, box_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			skin_s4 <= cov_c || box_s3;
			cov_s4  <= cov_c;
			box_s4  <= box_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {5'd0, box_s4, cov_s4, skin_s4};

endmodule

`default_nettype wire

// ===== rtl/spc_distance.sv =====
// Three-stage datapath for the weighted terms of the Mahalanobis distance.
`default_nettype none

module spc_distance (
	input  wire logic                                   clk,
	input  wire spc_pkg::spc_adv_t                      adv,
	input  wire logic [7:0]                             hue,
	input  wire logic [7:0]                             sat,
	input  wire logic [11:0]                            mean_hue_q4,
	input  wire logic [11:0]                            mean_sat_q4,
	output logic        [spc_pkg::TERM_A_W-1:0]         term_a_s3,
	output logic signed [spc_pkg::TERM_B_W-1:0]         term_b_s3,
	output logic        [spc_pkg::TERM_C_W-1:0]         term_c_s3
);
	import spc_pkg::*;

	logic signed [DIFF_W-1:0] dh_s1, ds_s1;
	logic signed [PROD_W-1:0] hh_s2, hs_s2, ss_s2;
	logic signed [PROD_W-1:0] hh_c, hs_c, ss_c;

	// Offsets from the model mean, both operands zero-extended to 13 bits.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			dh_s1 <= $signed({1'b0, hue, 4'b0000}) - $signed({1'b0, mean_hue_q4});
			ds_s1 <= $signed({1'b0, sat, 4'b0000}) - $signed({1'b0, mean_sat_q4});
		end
	end

	assign hh_c = dh_s1 * dh_s1;
	assign hs_c = dh_s1 * ds_s1;
	assign ss_c = ds_s1 * ds_s1;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			hh_s2 <= hh_c;
			hs_s2 <= hs_c;
			ss_s2 <= ss_c;
		end
	end

	// Squares are never negative and stay below 2^24.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			term_a_s3 <= hh_s2[SQ_W-1:0] * INV_A;
			term_b_s3 <= hs_s2 * INV_B2;
			term_c_s3 <= ss_s2[SQ_W-1:0] * INV_C;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_skin_pixel_classifier.sv =====
// Self-checking testbench for the skin pixel classifier: stream stimulus, register setup and scoreboard.
`timescale 1ns / 100ps

module tb_skin_pixel_classifier;

	import spc_pkg::*;

	// Inverse covariance weights of the skin model, unsigned Q.24, and the limits of the run.
	localparam longint WEIGHT_HH     = 101502;
	localparam longint WEIGHT_HS     = 7113;
	localparam longint WEIGHT_SS     = 6422;
	localparam int     NUM_REGS      = 8;
	localparam int     NUM_PHASES    = 8;
	localparam int     ITEMS_PER_PHASE = 125;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     CYCLE_LIMIT   = 400000;

	// One pixel as it travels on s_tdata: hue in the lowest byte, Cb in the highest.
	typedef struct packed {
		logic [7:0] cb;
		logic [7:0] cr;
		logic [7:0] val;
		logic [7:0] sat;
		logic [7:0] hue;
	} pixel_t;

	// The three flags of one classification.
	typedef struct {
		bit skin;
		bit cov_hit;
		bit box_hit;
	} verdict_t;

	// Patterns with which the receiver withholds m_tready.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_LONG
	} rx_mode_e;

	// Keeps a private copy of the registers, classifies every accepted pixel and holds the
	// verdicts in the order in which the block must return them.
	class skin_scoreboard;
		bit [5:0]  thr_lambda;
		bit [7:0]  thr_value;
		bit [7:0]  cr_lo;
		bit [7:0]  cr_hi;
		bit [7:0]  cb_lo;
		bit [7:0]  cb_hi;
		bit [11:0] mean_hue;
		bit [11:0] mean_sat;
		verdict_t  pending_q[$];
		int        mismatches;
		int        noted;
		int        checked;
		int        skin_seen;
		int        cov_seen;
		int        box_seen;

		function void load_defaults();
			thr_lambda = 6'd2;
			thr_value  = 8'd40;
			cr_lo      = 8'd128;
			cr_hi      = 8'd164;
			cb_lo      = 8'd91;
			cb_hi      = 8'd127;
			mean_hue   = 12'd1838;
			mean_sat   = 12'd905;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_THRESHOLD_LAMBDA: thr_lambda = value[5:0];
				REG_THRESHOLD_VALUE:  thr_value  = value[7:0];
				REG_CR_LOW:           cr_lo      = value[7:0];
				REG_CR_HIGH:          cr_hi      = value[7:0];
				REG_CB_LOW:           cb_lo      = value[7:0];
				REG_CB_HIGH:          cb_hi      = value[7:0];
				REG_MEAN_HUE_Q4:      mean_hue   = value[11:0];
				REG_MEAN_SAT_Q4:      mean_sat   = value[11:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] read_reg(logic [2:0] idx);
			case (idx)
				REG_THRESHOLD_LAMBDA: return {26'd0, thr_lambda};
				REG_THRESHOLD_VALUE:  return {24'd0, thr_value};
				REG_CR_LOW:           return {24'd0, cr_lo};
				REG_CR_HIGH:          return {24'd0, cr_hi};
				REG_CB_LOW:           return {24'd0, cb_lo};
				REG_CB_HIGH:          return {24'd0, cb_hi};
				REG_MEAN_HUE_Q4:      return {20'd0, mean_hue};
				REG_MEAN_SAT_Q4:      return {20'd0, mean_sat};
				default:              return 32'd0;
			endcase
		endfunction

		// The distance is exact in 64-bit signed arithmetic, so no rounding is modelled.
		function verdict_t classify(pixel_t px);
			verdict_t v;
			int       h;
			int       s;
			int       mh;
			int       ms;
			longint   dh;
			longint   ds;
			longint   lambda_q32;
			longint   limit;
			h     = px.hue;
			s     = px.sat;
			mh    = mean_hue;
			ms    = mean_sat;
			dh    = h * 16 - mh;
			ds    = s * 16 - ms;
			lambda_q32 = WEIGHT_HH * dh * dh + 2 * WEIGHT_HS * dh * ds + WEIGHT_SS * ds * ds;
			limit = longint'({26'd0, thr_lambda}) <<< 32;
			v.cov_hit = (px.val >= thr_value) && (lambda_q32 < limit);
			v.box_hit = (px.cr > cr_lo) && (px.cr < cr_hi) && (px.cb > cb_lo) && (px.cb < cb_hi);
			v.skin    = v.cov_hit || v.box_hit;
			return v;
		endfunction

		function void note_pixel(pixel_t px);
			pending_q.push_back(classify(px));
			noted++;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch: %s", $time, msg);
		endfunction

		function void check_verdict(logic [7:0] data);
			verdict_t want;
			if (pending_q.size() == 0) begin
				flag($sformatf("result %b with no pixel outstanding", data[2:0]));
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (data[0] !== want.skin || data[1] !== want.cov_hit || data[2] !== want.box_hit)
				flag($sformatf("result %0d: expected skin=%0b cov=%0b box=%0b, got skin=%b cov=%b box=%b",
					checked, want.skin, want.cov_hit, want.box_hit, data[0], data[1], data[2]));
			if (data[0] === 1'b1) skin_seen++;
			if (data[1] === 1'b1) cov_seen++;
			if (data[2] === 1'b1) box_seen++;
		endfunction

		function void check_readback(logic [2:0] idx, logic [31:0] data);
			if (data !== read_reg(idx))
				flag($sformatf("register %0d read %h, expected %h", idx, data, read_reg(idx)));
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	skin_scoreboard sb;
	int             cycle_count;
	int             phases_run;

	skin_pixel_classifier uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // hue[7:0], sat[15:8], val[23:16], cr[31:24], cb[39:32]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // skin[0], cov_hit[1], box_hit[2], zeros above
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The cycle counter is the only watchdog. It is far above the slowest legal run, in which
	// every pixel would see the longest sender gap, the longest receiver stall and the full
	// pipeline latency, with every register phase and drain added on top.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, sb.outstanding());
			$display("[skin_pixel_classifier] ERROR");
			$finish;
		end
	end

	// Receiver. Every edge at which m_tvalid and m_tready are both high completes a result
	// transaction, and the sampled flags are checked against the oldest outstanding verdict.
	// m_tready then follows one of several patterns, each held for a random number of cycles,
	// so that stalls land on every pipeline stage and there are also long stretches without any.
	rx_mode_e rx_mode;
	int       rx_mode_left;
	int       rx_period;
	int       rx_hold_left;
	bit       rx_hold_state;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_verdict(m_tdata);
		if (rx_mode_left <= 0) begin
			rx_mode      = rx_mode_e'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(32, 256);
			rx_period    = $urandom_range(2, 5);
		end
		rx_mode_left--;
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (cycle_count % rx_period) != 0;
			RX_LONG: begin
				if (rx_hold_left <= 0) begin
					rx_hold_state = ~rx_hold_state;
					rx_hold_left  = rx_hold_state ? $urandom_range(1, 6) : $urandom_range(1, 12);
				end
				rx_hold_left--;
				m_tready <= rx_hold_state;
			end
			default:     m_tready <= 1'b1;
		endcase
	end

	function automatic logic [7:0] clamp8(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// Picks a chroma value that mostly sits on or just beside a bound, or between the two bounds.
	function automatic logic [7:0] near_bound(int lo, int hi);
		int pick;
		int off;
		pick = $urandom_range(0, 3);
		off  = $urandom_range(0, 2);
		case (pick)
			0:       return clamp8(lo + off - 1);
			1:       return clamp8(hi + off - 1);
			2:       return 8'($urandom_range(lo, hi));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t make_pixel(int hue, int sat, int val, int cr, int cb);
		pixel_t px;
		px.hue = 8'(hue);
		px.sat = 8'(sat);
		px.val = 8'(val);
		px.cr  = 8'(cr);
		px.cb  = 8'(cb);
		return px;
	endfunction

	// Most pixels are placed around the current skin model and the current box, so that both
	// tests are decided close to their limits; the rest are uniform noise over all byte values.
	function automatic pixel_t random_pixel();
		pixel_t px;
		int     hc;
		int     sc;
		int     off_h;
		int     off_s;
		int     off_v;
		if ($urandom_range(0, 9) < 7) begin
			hc     = sb.mean_hue >> 4;
			sc     = sb.mean_sat >> 4;
			off_h  = $urandom_range(0, 48);
			off_s  = $urandom_range(0, 80);
			off_v  = $urandom_range(0, 6);
			px.hue = clamp8(hc + off_h - 24);
			px.sat = clamp8(sc + off_s - 40);
			if ($urandom_range(0, 1))
				px.val = clamp8(int'(sb.thr_value) + off_v - 3);
			else
				px.val = 8'($urandom_range(0, 255));
			px.cr  = near_bound(sb.cr_lo, sb.cr_hi);
			px.cb  = near_bound(sb.cb_lo, sb.cb_hi);
		end else begin
			px = {$urandom, 8'($urandom)};
		end
		return px;
	endfunction

	// Offers one pixel and returns at the edge at which the transaction completes. s_tvalid is
	// left high so that a following pixel can go out on the very next cycle.
	task automatic send_pixel(input pixel_t px);
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(px);
	endtask

	task automatic sender_gap(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Holds the sender back until every outstanding verdict has been returned, then lets the
	// pipeline settle; the registers may only be changed after this.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then the access cycle, at whose closing edge the register loads.
	// The upper bits of pwdata carry noise, which the block must ignore.
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value, input int width);
		logic [31:0] noisy;
		noisy        = ($urandom << width) | value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= noisy;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, noisy);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_readback_all();
		for (int i = 0; i < NUM_REGS; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= {3'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			sb.check_readback(3'(i), prdata);
			psel    <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic program_model(input int lam, input int tv, input int crl, input int crh,
		input int cbl, input int cbh, input int mh, input int ms);
		apb_write(REG_THRESHOLD_LAMBDA, lam, 6);
		apb_write(REG_THRESHOLD_VALUE,  tv,  8);
		apb_write(REG_CR_LOW,           crl, 8);
		apb_write(REG_CR_HIGH,          crh, 8);
		apb_write(REG_CB_LOW,           cbl, 8);
		apb_write(REG_CB_HIGH,          cbh, 8);
		apb_write(REG_MEAN_HUE_Q4,      mh,  12);
		apb_write(REG_MEAN_SAT_Q4,      ms,  12);
		apb_readback_all();
	endtask

	// Random pixels in bursts of random length separated by random gaps, with zero-length gaps
	// common enough to give long back-to-back stretches. On request the sender stops halfway
	// and waits for the pipeline to empty completely before carrying on.
	task automatic stream_random(input int count, input bit pause_midway);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				send_pixel(random_pixel());
				burst--;
				left--;
				if (pause_midway && left == count / 2)
					drain_results();
			end
			sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
		end
	endtask

	initial begin
		int lam;
		int crl;
		int crh;
		int cbl;
		int cbh;
		sb = new();
		sb.load_defaults();
		cycle_count   = 0;
		phases_run    = 0;
		rx_mode_left  = 0;
		rx_hold_left  = 0;
		rx_hold_state = 1'b0;
		// Every input is known from time zero; reset is applied once, at the start of the run.
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values of all registers, then directed pixels against the default model: the
		// brightness threshold, the open bounds of the box on each side, hue beyond 179,
		// all-zero and all-ones pixels and offsets in each direction from the model mean.
		apb_readback_all();
		send_pixel(make_pixel(115, 57, 40, 0, 0));
		send_pixel(make_pixel(115, 57, 39, 0, 0));
		send_pixel(make_pixel(0, 0, 0, 0, 0));
		send_pixel(make_pixel(255, 255, 255, 255, 255));
		sender_gap(3);
		send_pixel(make_pixel(179, 255, 255, 129, 92));
		send_pixel(make_pixel(180, 57, 200, 128, 100));
		send_pixel(make_pixel(115, 57, 255, 163, 126));
		send_pixel(make_pixel(115, 57, 255, 164, 126));
		send_pixel(make_pixel(115, 57, 255, 130, 91));
		send_pixel(make_pixel(115, 57, 255, 130, 127));
		sender_gap(1);
		send_pixel(make_pixel(100, 57, 255, 0, 0));
		send_pixel(make_pixel(115, 30, 255, 0, 0));
		send_pixel(make_pixel(130, 80, 255, 0, 0));
		send_pixel(make_pixel(0, 255, 255, 150, 110));
		send_pixel(make_pixel(255, 0, 128, 150, 110));
		send_pixel(make_pixel(125, 57, 100, 0, 0));
		send_pixel(make_pixel(115, 70, 100, 0, 0));
		send_pixel(make_pixel(105, 45, 100, 0, 0));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			case (ph)
				0: begin
					// Zero distance limit, so the covariance test can never pass, and the widest box.
					program_model(0, 0, 0, 255, 0, 255, 0, 0);
					send_pixel(make_pixel(0, 0, 0, 0, 255));
					send_pixel(make_pixel(0, 0, 255, 255, 1));
					send_pixel(make_pixel(0, 0, 255, 1, 254));
				end
				1: begin
					// A distance limit of 50, the top brightness threshold, both boxes empty and the
					// mean at its maximum.
					program_model(50, 255, 200, 201, 255, 0, 4095, 4095);
					send_pixel(make_pixel(255, 255, 255, 200, 255));
					send_pixel(make_pixel(255, 255, 254, 201, 0));
					send_pixel(make_pixel(0, 0, 255, 255, 128));
				end
				2: program_model(63, 1, 254, 255, 0, 2, 0, 4095);
				default: begin
					lam = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
					crl = $urandom_range(0, 200);
					crh = crl + $urandom_range(0, 55);
					cbl = $urandom_range(0, 200);
					cbh = cbl + $urandom_range(0, 55);
					program_model(lam, $urandom_range(0, 255), crl, crh, cbl, cbh,
						$urandom_range(0, 4095), $urandom_range(0, 4095));
				end
			endcase
			stream_random(ITEMS_PER_PHASE, ph == 4);
			phases_run++;
		end

		drain_results();
		$display("Covered %0d pixels over %0d register settings; %0d results checked.",
			sb.noted, phases_run + 1, sb.checked);
		$display("Flags seen: skin %0d, covariance %0d, box %0d; mismatches %0d.",
			sb.skin_seen, sb.cov_seen, sb.box_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("[skin_pixel_classifier] OK");
		else
			$display("[skin_pixel_classifier] ERROR");
		$finish;
	end

endmodule
